// File: src/polygon_support_point_unit_macros.svh
// assertion macros for the polygon support point unit
`ifndef POLYGON_SUPPORT_POINT_UNIT_MACROS_SVH
`define POLYGON_SUPPORT_POINT_UNIT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define PSP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define PSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/psp_pkg.sv
// package: sequencer states and operation codes of the support point unit
package psp_pkg;

   // width of the coordinate ports
   localparam int COORD_PORT_W = 32;

   // operation codes on the request channel
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // query sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_OUTPUT
   } state_type;

endpackage

// File: src/polygon_support_point_unit.sv
// Support point of a convex polygon held in a vertex memory.
// A load gives no result. A query presents its result once its vertices have
// been scanned and the pipeline has drained (count clamped to 1..MAX_VERTICES);
// the next item is taken once the query leaves the sequencer, so queries do not
// overlap: the vertex memory's single read port sets the scan rate.
// Synchronous active-high reset: sequencer idle, no result pending, vertex_count 1.
module polygon_support_point_unit
   import psp_pkg::*;
#(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [3:0]                     req_vertex_index,
   input  logic signed [COORD_PORT_W-1:0] req_coord_x,
   input  logic signed [COORD_PORT_W-1:0] req_coord_y,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [3:0]                     rsp_best_index,
   output logic signed [COORD_PORT_W-1:0] rsp_best_x,
   output logic signed [COORD_PORT_W-1:0] rsp_best_y,
   // configuration channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [4:0]                     csr_vertex_count
);

`include "polygon_support_point_unit_macros.svh"

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CB = COORD_BITS;
   localparam int PW = 2 * CB;
   localparam int SW = 2 * CB + 1;

   // configuration register
   logic [4:0] count_ff;

   // sequencer
   state_type state_ff, state_in;
   logic [AW-1:0] scan_idx_ff, scan_idx_in;
   logic [AW-1:0] last_idx_ff, last_idx_in;
   logic signed [CB-1:0] dir_x_ff, dir_y_ff;

   // memory ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [2*CB-1:0]   wr_data;
   logic              rd_en;
   logic [2*CB-1:0]   rd_data;

   // pipeline stage 1: read data
   logic          s1_vld_ff, s1_last_ff;
   logic [AW-1:0] s1_idx_ff;
   logic signed [CB-1:0] s1_x, s1_y;

   // pipeline stage 2: products
   logic          s2_vld_ff, s2_last_ff;
   logic [AW-1:0] s2_idx_ff;
   logic signed [CB-1:0] s2_x_ff, s2_y_ff;
   logic signed [PW-1:0] s2_p1_ff, s2_p2_ff;

   // pipeline stage 3: dot product
   logic          s3_vld_ff, s3_last_ff;
   logic [AW-1:0] s3_idx_ff;
   logic signed [CB-1:0] s3_x_ff, s3_y_ff;
   logic signed [SW-1:0] s3_sum_ff;

   // running best
   logic                 first_ff;
   logic [AW-1:0]        best_idx_ff;
   logic signed [CB-1:0] best_x_ff, best_y_ff;
   logic signed [SW-1:0] best_sum_ff;
   logic                 take_new;

   // output register
   logic                           rsp_valid_ff;
   logic [3:0]                     rsp_index_ff;
   logic signed [COORD_PORT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                           rsp_free;
   logic                           rsp_load;

   logic req_xfer;
   logic query_start;

   assign req_xfer    = req_valid && req_ready;
   assign query_start = req_xfer && (req_op == OP_QUERY);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign csr_ready   = 1'b1;

   // vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_vertex_count;
      end
   end

   // clamp the count to 1..MAX_VERTICES and keep the last scanned slot
   always_comb begin
      if (count_ff == 5'd0) begin
         last_idx_in = '0;
      end else if (32'(count_ff) > MAX_VERTICES) begin
         last_idx_in = AW'(MAX_VERTICES - 1);
      end else begin
         last_idx_in = AW'(count_ff - 5'd1);
      end
   end

   // loads write straight into the vertex memory
   assign wr_en   = req_xfer && (req_op == OP_LOAD) &&
                    (32'(req_vertex_index) < MAX_VERTICES);
   assign wr_addr = AW'(req_vertex_index);
   assign wr_data = {req_coord_y[CB-1:0], req_coord_x[CB-1:0]};
   assign rd_en   = (state_ff == ST_SCAN);

   psp_ram #(
      .WIDTH (2 * CB),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and outputs
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            scan_idx_in = '0;
            if (query_start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + AW'(1);
            if (scan_idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s3_vld_ff && s3_last_ff) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // scan counter and query operands
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (query_start) begin
         last_idx_ff <= last_idx_in;
         dir_x_ff    <= req_coord_x[CB-1:0];
         dir_y_ff    <= req_coord_y[CB-1:0];
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_en;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   assign s1_x = rd_data[CB-1:0];
   assign s1_y = rd_data[2*CB-1:CB];

   // stage payloads: read tag, products, sum
   always_ff @(posedge clock) begin
      s1_idx_ff  <= scan_idx_ff;
      s1_last_ff <= (scan_idx_ff == last_idx_ff);

      s2_idx_ff  <= s1_idx_ff;
      s2_last_ff <= s1_last_ff;
      s2_x_ff    <= s1_x;
      s2_y_ff    <= s1_y;
      s2_p1_ff   <= s1_x * dir_x_ff;
      s2_p2_ff   <= s1_y * dir_y_ff;

      s3_idx_ff  <= s2_idx_ff;
      s3_last_ff <= s2_last_ff;
      s3_x_ff    <= s2_x_ff;
      s3_y_ff    <= s2_y_ff;
      s3_sum_ff  <= SW'(s2_p1_ff) + SW'(s2_p2_ff);
   end

   // strictly greater wins, so a tie keeps the lower index
   assign take_new = s3_vld_ff && (first_ff || (s3_sum_ff > best_sum_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (query_start) begin
         first_ff <= 1'b1;
      end else if (s3_vld_ff) begin
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_new) begin
         best_idx_ff <= s3_idx_ff;
         best_x_ff   <= s3_x_ff;
         best_y_ff   <= s3_y_ff;
         best_sum_ff <= s3_sum_ff;
      end
   end

   // response register: holds a result while the next item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= 4'(best_idx_ff);
         rsp_x_ff     <= COORD_PORT_W'(best_x_ff);
         rsp_y_ff     <= COORD_PORT_W'(best_y_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_index = rsp_index_ff;
   assign rsp_best_x     = rsp_x_ff;
   assign rsp_best_y     = rsp_y_ff;

   // checks
   `PSP_ASSERT_SAME(a_idle_pipe_empty, clock, reset, (state_ff == ST_IDLE), (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff), "pipeline busy while idle")
   `PSP_ASSERT_SAME(a_scan_in_range, clock, reset, (state_ff == ST_SCAN), (scan_idx_ff <= last_idx_ff), "scan past last vertex")
   `PSP_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == ST_OUTPUT && rsp_free), (rsp_valid_ff && state_ff == ST_IDLE), "result transfer not staged")

endmodule

// File: src/psp_ram.sv
// generic single-write, single-read memory with registered read data
module psp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
